FILE: sv/blpd_pkg.sv
// Shared constants, register indexes and the quarter-cosine table builder
// for the breathing-LED duty generator. No dependencies.
package blpd_pkg;

   localparam logic [15:0] MIN_PERIOD_DEF = 16'd500;
   localparam logic [15:0] MAX_PERIOD_DEF = 16'd10000;

   localparam logic [15:0] PERIOD_RESET = 16'd2000;
   localparam logic        ENABLE_RESET = 1'b1;
   localparam logic [15:0] TOP_RESET    = 16'd999;

   // Phase resolution of one breath cycle; a power of two
   localparam int PHASE_STEPS = 1024;
   localparam int PHASE_BITS  = $clog2(PHASE_STEPS);
   localparam int QTR_STEPS   = PHASE_STEPS / 4;
   localparam int QTR_BITS    = PHASE_BITS - 2;
   localparam int ROM_AW      = $clog2(QTR_STEPS + 1);
   localparam int U_SHIFT     = 30 - QTR_BITS;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_ENABLE = 2'd1;
   localparam logic [1:0] REG_TOP    = 2'd2;

   localparam int CSR_AW = 4;

   localparam longint Q30_ONE     = 64'sd1073741824;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef logic [15:0] cos_table_type [0:QTR_STEPS];

   // Cosine magnitude in Q1.15 (0..32768) for each quarter-turn step,
   // from a Q30 Taylor series in nested form
   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      longint u;
      longint x;
      longint x2;
      longint h;
      for (int k = 0; k <= QTR_STEPS; k++) begin
         u  = longint'(k) * (longint'(1) << U_SHIFT);
         x  = (u * HALF_PI_Q30) / Q30_ONE;
         x2 = (x * x) / Q30_ONE;
         h  = Q30_ONE - x2 / 90;
         h  = Q30_ONE - ((x2 * h) / Q30_ONE) / 56;
         h  = Q30_ONE - ((x2 * h) / Q30_ONE) / 30;
         h  = Q30_ONE - ((x2 * h) / Q30_ONE) / 12;
         h  = Q30_ONE - ((x2 * h) / Q30_ONE) / 2;
         if (h < 0) h = 0;
         if (h > Q30_ONE) h = Q30_ONE;
         tbl[k] = 16'((h + 16384) / 32768);
      end
      return tbl;
   endfunction

endpackage

FILE: sv/breathing_led_pwm_duty_top.sv
// Breathing-LED duty generator: tick events in, PWM compare words out.
// Depends on blpd_pkg (constants, register indexes, cosine table builder).
//
//   channel  direction  signals
//   req      in         req_valid, req_ready, req_from_tick_timer
//   rsp      out        rsp_valid, rsp_ready, rsp_compare_value
//   csr      in/out     csr_psel, csr_penable, csr_pwrite, csr_paddr,
//                       csr_pwdata, csr_prdata, csr_pready
//
// A tick word passes from accept to rsp_valid through the serial phase
// divider (one quotient bit per cycle), the registered cosine ROM read, the
// duty multiply and the load of the output register. A disabled tick goes
// straight to the output register with a zero compare value; a non-tick word
// gives no result and leaves req ready. Reset is synchronous; a finished word waits
// in the output register while the next word is accepted, and the sequencer
// holds if that register is full.
module breathing_led_pwm_duty_top #(
   parameter logic [15:0] MIN_PERIOD = blpd_pkg::MIN_PERIOD_DEF,
   parameter logic [15:0] MAX_PERIOD = blpd_pkg::MAX_PERIOD_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_from_tick_timer,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [15:0]                  rsp_compare_value,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [blpd_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import blpd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam int CNT_W = $clog2(PHASE_BITS);
   localparam logic [CNT_W-1:0] CNT_START = CNT_W'(PHASE_BITS - 1);
   localparam logic [ROM_AW-1:0] QTR_IDX = ROM_AW'(QTR_STEPS);

   // Quarter-cosine ROM
   localparam cos_table_type COS_TABLE = build_cos_table();

   logic [2:0]            state_ff, state_in;
   logic [15:0]           period_ff, period_in;
   logic                  enable_ff, enable_in;
   logic [15:0]           top_ff, top_in;
   logic [15:0]           phase_ff, phase_in;
   logic [15:0]           rem_ff, rem_in;
   logic [PHASE_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [15:0]           rom_ff;
   logic                  neg_ff;
   logic [31:0]           prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_cmp_ff, rsp_cmp_in;

   logic                  req_acc;
   logic                  csr_wr;
   logic [1:0]            csr_idx;
   logic [15:0]           wr_period;
   logic [15:0]           phase_inc;
   logic [16:0]           rem_sh;
   logic                  rem_ge;
   logic [1:0]            quad;
   logic [QTR_BITS-1:0]   quad_pos;
   logic [ROM_AW-1:0]     rom_addr;
   logic [15:0]           mag;
   logic [16:0]           duty_diff;
   logic [32:0]           duty_prod;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx   = csr_paddr[3:2];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_compare_value = rsp_cmp_ff;

   always_comb begin
      case (csr_idx)
         REG_PERIOD: csr_prdata = {16'd0, period_ff};
         REG_ENABLE: csr_prdata = {31'd0, enable_ff};
         REG_TOP:    csr_prdata = {16'd0, top_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   // Clamp low first, then high
   always_comb begin
      wr_period = csr_pwdata[15:0];
      if (wr_period < MIN_PERIOD) wr_period = MIN_PERIOD;
      if (wr_period > MAX_PERIOD) wr_period = MAX_PERIOD;
   end

   assign phase_inc = phase_ff + 16'd1;
   assign rem_sh    = {rem_ff, 1'b0};
   assign rem_ge    = (rem_sh >= {1'b0, period_ff});

   // Fold the phase index onto the first quarter
   assign quad     = quot_ff[PHASE_BITS-1 -: 2];
   assign quad_pos = quot_ff[QTR_BITS-1:0];
   assign rom_addr = quad[0] ? (QTR_IDX - ROM_AW'(quad_pos)) : ROM_AW'(quad_pos);

   // 32768 - c, with the positive peak saturated to 32767
   always_comb begin
      mag = rom_ff;
      if (neg_ff) begin
         duty_diff = 17'd32768 + {1'b0, mag};
      end else begin
         if (mag > 16'd32767) mag = 16'd32767;
         duty_diff = 17'd32768 - {1'b0, mag};
      end
   end
   assign duty_prod = {1'b0, top_ff} * duty_diff;

   always_comb begin
      state_in     = state_ff;
      period_in    = period_ff;
      enable_in    = enable_ff;
      top_in       = top_ff;
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cmp_in   = rsp_cmp_ff;

      if (csr_wr) begin
         case (csr_idx)
            REG_PERIOD: begin
               period_in = wr_period;
               phase_in  = 16'd0;
            end
            REG_ENABLE: enable_in = csr_pwdata[0];
            REG_TOP:    top_in    = csr_pwdata[15:0];
            default:    ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc && req_from_tick_timer) begin
               if (!enable_ff) begin
                  prod_in  = 32'd0;
                  state_in = S_DONE;
               end else begin
                  // advance and wrap the phase, then seed the divider
                  phase_in = (phase_inc >= period_ff) ? 16'd0 : phase_inc;
                  rem_in   = (phase_inc >= period_ff) ? 16'd0 : phase_inc;
                  quot_in  = '0;
                  cnt_in   = CNT_START;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in  = rem_ge ? 16'(rem_sh - {1'b0, period_ff}) : rem_sh[15:0];
            quot_in = {quot_ff[PHASE_BITS-2:0], rem_ge};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) state_in = S_READ;
         end
         S_READ: state_in = S_MUL;
         S_MUL: begin
            prod_in  = duty_prod[31:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cmp_in   = prod_ff[31:16];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= PERIOD_RESET;
         enable_ff    <= ENABLE_RESET;
         top_ff       <= TOP_RESET;
         phase_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         enable_ff    <= enable_in;
         top_ff       <= top_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      cnt_ff     <= cnt_in;
      prod_ff    <= prod_in;
      rsp_cmp_ff <= rsp_cmp_in;
   end

   // Registered ROM read, with the quadrant sign carried alongside
   always_ff @(posedge clock) begin
      rom_ff <= COS_TABLE[rom_addr];
      neg_ff <= quad[1] ^ quad[0];
   end

endmodule

FILE: verif/breathing_led_pwm_duty_top_tb.sv
// Self-checking testbench for breathing_led_pwm_duty_top: random tick words in bursts,
// APB register phases, and a raised-cosine duty predictor checked against rsp.
// Depends on blpd_pkg and the breathing_led_pwm_duty_top RTL.

class duty_scoreboard;
   logic [15:0] period_q;
   logic        enable_q;
   logic [15:0] top_q;
   logic [15:0] phase_q;
   logic [15:0] compare_q [$];
   int          mismatches;

   function new();
      period_q   = blpd_pkg::PERIOD_RESET;
      enable_q   = blpd_pkg::ENABLE_RESET;
      top_q      = blpd_pkg::TOP_RESET;
      phase_q    = 16'd0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] value);
      logic [15:0] v;
      v = value[15:0];
      case (idx)
         blpd_pkg::REG_PERIOD: begin
            if (v < blpd_pkg::MIN_PERIOD_DEF) v = blpd_pkg::MIN_PERIOD_DEF;
            if (v > blpd_pkg::MAX_PERIOD_DEF) v = blpd_pkg::MAX_PERIOD_DEF;
            period_q = v;
            phase_q  = 16'd0;
         end
         blpd_pkg::REG_ENABLE: enable_q = value[0];
         blpd_pkg::REG_TOP:    top_q    = v;
         default: ;
      endcase
   endfunction

   // Q30 cosine over a quarter turn, nested Taylor form, truncating division
   function longint cos_quarter_q30(longint u);
      longint one;
      longint x;
      longint x2;
      longint h;
      one = blpd_pkg::Q30_ONE;
      x   = (u * blpd_pkg::HALF_PI_Q30) / one;
      x2  = (x * x) / one;
      h   = one - x2 / 90;
      h   = one - ((x2 * h) / one) / 56;
      h   = one - ((x2 * h) / one) / 30;
      h   = one - ((x2 * h) / one) / 12;
      h   = one - ((x2 * h) / one) / 2;
      if (h < 0) h = 0;
      if (h > one) h = one;
      return h;
   endfunction

   function logic [15:0] duty_at_phase();
      longint idx;
      longint turn;
      longint quad;
      longint rem;
      longint arg;
      longint mag;
      longint cosv;
      longint duty;
      idx  = (longint'(phase_q) * blpd_pkg::PHASE_STEPS) / longint'(period_q);
      turn = (idx <<< 32) / blpd_pkg::PHASE_STEPS;
      quad = (turn >>> 30) & 3;
      rem  = turn & (blpd_pkg::Q30_ONE - 1);
      arg  = (quad == 0 || quad == 2) ? rem : blpd_pkg::Q30_ONE - rem;
      mag  = (cos_quarter_q30(arg) + 16384) / 32768;
      if (quad == 1 || quad == 2) cosv = -mag;
      else cosv = (mag > 32767) ? 32767 : mag;
      duty = (longint'(top_q) * (32768 - cosv)) >>> 16;
      return duty[15:0];
   endfunction

   function void note_word(logic tick);
      if (!tick) return;
      if (!enable_q) begin
         compare_q.push_back(16'd0);
         return;
      end
      if (period_q == 16'd0) return;
      phase_q = phase_q + 16'd1;
      if (phase_q >= period_q) phase_q = 16'd0;
      compare_q.push_back(duty_at_phase());
   endfunction

   function void check_word(logic [15:0] got);
      logic [15:0] want;
      if (compare_q.size() == 0) begin
         if (mismatches < 10) $display("unexpected rsp word: compare_value=%0d", got);
         mismatches++;
         return;
      end
      want = compare_q.pop_front();
      if (got !== want) begin
         if (mismatches < 10)
            $display("compare_value mismatch: expected %0d, actual %0d", want, got);
         mismatches++;
      end
   endfunction

   function int pending();
      return compare_q.size();
   endfunction
endclass

module breathing_led_pwm_duty_top_tb;
   import blpd_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int RANDOM_TICKS = 940;
   localparam int DRAIN_CYCLES = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_from_tick_timer = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [15:0]         rsp_compare_value;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = 32'd0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   duty_scoreboard sb = new();
   int          stall_mode = 0;
   logic [31:0] stall_cnt = 32'd0;

   breathing_led_pwm_duty_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_from_tick_timer (req_from_tick_timer),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_compare_value   (rsp_compare_value),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #6 clock = ~clock;

   // Receiver: check each accepted word, then pick the next ready value
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_compare_value);
      stall_cnt <= stall_cnt + 32'd1;
      if (stall_cnt % 150 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 4) == 0);
         default: rsp_ready <= stall_cnt[2];
      endcase
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Leaves req_valid high; the caller drops it when the burst ends
   task automatic send_word(input logic tick);
      req_valid           <= 1'b1;
      req_from_tick_timer <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(tick);
   endtask

   // Drop valid, drain every expected word, then cover any silent work in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic drive_ticks(input int n);
      int   done;
      int   burst;
      int   gap;
      logic tick;
      done = 0;
      while (done < n) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && done < n; k++) begin
            tick = ($urandom_range(0, 99) < 85);
            send_word(tick);
            if (tick) done++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] with_noise(input logic [15:0] low);
      return ($urandom() & 32'hFFFF_0000) | {16'd0, low};
   endfunction

   initial begin
      int          ticks_done;
      int          len;
      logic [15:0] pv;
      logic [15:0] tv;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: reset defaults, ignored events, disabled ticks, register extremes
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b1);
      send_word(1'b1);
      settle();
      write_csr(REG_ENABLE, 32'hFFFF_FFFE);
      send_word(1'b1);
      send_word(1'b0);
      send_word(1'b1);
      settle();
      write_csr(REG_ENABLE, 32'h0000_0001);
      write_csr(REG_UNUSED, $urandom());
      write_csr(REG_TOP, 32'hFFFF_0000);
      send_word(1'b1);
      send_word(1'b1);
      settle();
      write_csr(REG_TOP, 32'h0000_FFFF);
      write_csr(REG_PERIOD, 32'h0000_0000);
      send_word(1'b1);
      send_word(1'b1);
      send_word(1'b1);
      settle();
      write_csr(REG_PERIOD, 32'h0000_FFFF);
      send_word(1'b1);
      send_word(1'b1);
      settle();
      write_csr(REG_PERIOD, 32'd499);
      send_word(1'b1);
      settle();
      write_csr(REG_PERIOD, 32'd10001);
      send_word(1'b1);
      settle();
      write_csr(REG_PERIOD, 32'd1);
      write_csr(REG_TOP, 32'd1);
      send_word(1'b1);
      settle();

      // Random: first phase wraps a shortest-period breath at full scale
      ticks_done = 0;
      write_csr(REG_PERIOD, with_noise(16'($urandom_range(0, 499))));
      write_csr(REG_TOP, with_noise(16'hFFFF));
      write_csr(REG_ENABLE, with_noise(16'd1));
      drive_ticks(560);
      ticks_done += 560;
      settle();

      while (ticks_done < RANDOM_TICKS) begin
         case ($urandom_range(0, 3))
            0:       pv = 16'($urandom_range(0, 499));
            1:       pv = 16'($urandom_range(500, 1200));
            2:       pv = 16'($urandom_range(0, 65535));
            default: pv = 16'($urandom_range(9000, 65535));
         endcase
         case ($urandom_range(0, 4))
            0:       tv = 16'hFFFF;
            1:       tv = 16'($urandom_range(0, 15));
            default: tv = 16'($urandom_range(0, 65535));
         endcase
         write_csr(REG_PERIOD, with_noise(pv));
         write_csr(REG_TOP, with_noise(tv));
         write_csr(REG_ENABLE, with_noise({15'd0, ($urandom_range(0, 5) != 0)}));
         len = $urandom_range(60, 240);
         if (len > RANDOM_TICKS - ticks_done) len = RANDOM_TICKS - ticks_done;
         drive_ticks(len);
         ticks_done += len;
         settle();
      end

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("breathing_led_pwm_duty_top test passed");
      end else begin
         $display("breathing_led_pwm_duty_top test failed");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("breathing_led_pwm_duty_top test failed");
      $finish;
   end

endmodule

FILE: files.f
sv/blpd_pkg.sv
sv/breathing_led_pwm_duty_top.sv
verif/breathing_led_pwm_duty_top_tb.sv
